@@ design/ess_pkg.sv @@
// Shared types and codes of the event slot scheduler.
package ess_pkg;

  localparam int TimeW = 63;
  localparam int CodeW = 8;
  localparam int PayW  = 16;
  localparam int SlotW = 5;
  localparam int CmdW  = 3;
  localparam int KindW = 2;
  localparam int MaskW = 32;

  localparam logic [TimeW-1:0] NeverTime = {TimeW{1'b1}};

  localparam logic [CmdW-1:0] CmdSchedAbs   = 3'd0;
  localparam logic [CmdW-1:0] CmdSchedRel   = 3'd1;
  localparam logic [CmdW-1:0] CmdReschedAbs = 3'd2;
  localparam logic [CmdW-1:0] CmdReschedRel = 3'd3;
  localparam logic [CmdW-1:0] CmdDisable    = 3'd4;
  localparam logic [CmdW-1:0] CmdCancel     = 3'd5;
  localparam logic [CmdW-1:0] CmdRunUntil   = 3'd6;

  localparam logic [KindW-1:0] KindAck  = 2'd0;
  localparam logic [KindW-1:0] KindDue  = 2'd1;
  localparam logic [KindW-1:0] KindDone = 2'd2;

  typedef struct packed {
    logic [TimeW-1:0] trig;
    logic [CodeW-1:0] code;
    logic [PayW-1:0]  payload;
  } slot_entry_t;

  localparam slot_entry_t EntryReset = '{trig: NeverTime, code: '0, payload: '0};

endpackage

@@ design/ess_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module ess_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/event_slot_scheduler_top.sv @@
// Event slot scheduler: slot table in RAM, command sequencer and run-until scan.
// Slot commands: after accept, one RAM read, then write-back with the result.
// Run-until: one slot per cycle through the RAM read port, except while a due item
// waits on a held output register.
// One command at a time; the next is accepted while the last result waits.
// Reset clears per-slot valid bits at once (invalid slots read as never/zero).
module event_slot_scheduler_top #(
  parameter int SLOT_TOTAL = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_axis_tvalid,
  output logic           s_axis_tready,
  // command[2:0], slot_index[7:3], time_value[70:8], now_time[133:71],
  // event_code[141:134], event_payload[157:142], zero fill
  input  logic [159:0]   s_axis_tdata,
  output logic           m_axis_tvalid,
  input  logic           m_axis_tready,
  // due_slot[4:0], due_code[12:5], due_payload[28:13], earliest_trigger[91:29]
  output logic [95:0]    m_axis_tdata,
  // item_kind[1:0]
  output logic [1:0]     m_axis_tuser,
  output logic           m_axis_tlast,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [ess_pkg::MaskW-1:0] cfg_data_i
);
  import ess_pkg::*;

  localparam int IdxW = $clog2(SLOT_TOTAL);
  localparam logic [6:0] SlotTotalV = 7'(SLOT_TOTAL);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(SLOT_TOTAL - 1);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StCmd  = 2'd1;
  localparam logic [1:0] StRun  = 2'd2;
  localparam logic [1:0] StFin  = 2'd3;

  logic [1:0] state_q, state_d;
  logic [MaskW-1:0] mask_q;

  logic [CmdW-1:0]  cmd_q;
  logic [SlotW-1:0] slot_q;
  logic [TimeW-1:0] time_q, now_q;
  logic [CodeW-1:0] code_q;
  logic [PayW-1:0]  pay_q;

  logic [IdxW-1:0]  idx_q, idx_d;
  logic [TimeW-1:0] min_q, min_d;
  logic [TimeW-1:0] earliest_q, earliest_d;
  logic [SLOT_TOTAL-1:0] vld_q;
  logic rd_vld_q;

  logic [IdxW-1:0] rd_addr, waddr;
  logic we;
  slot_entry_t wdata, rdata, entry;

  logic out_free, load, in_accept;
  logic ov_q;
  logic [KindW-1:0] okind_q, okind_d;
  logic [SlotW-1:0] oslot_q, oslot_d;
  logic [CodeW-1:0] ocode_q, ocode_d;
  logic [PayW-1:0]  opay_q, opay_d;
  logic [TimeW-1:0] oearl_q, oearl_d;
  logic olast_q, olast_d;

  logic [TimeW:0]   sum;
  logic [TimeW-1:0] nt, post;
  logic ok, due, ac;

  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == StIdle);
  assign cfg_ready_o   = 1'b1;
  assign out_free      = !ov_q || m_axis_tready;
  assign entry         = rd_vld_q ? rdata : EntryReset;

  assign sum = {1'b0, now_q} + {1'b0, time_q};
  assign nt  = (cmd_q == CmdSchedRel || cmd_q == CmdReschedRel)
             ? (sum[TimeW] ? NeverTime : sum[TimeW-1:0]) : time_q;
  assign ok  = {2'b00, slot_q} < SlotTotalV;
  assign due = entry.trig <= time_q;
  assign ac  = (7'(idx_q) < 7'd32) && (((mask_q >> idx_q) & 32'd1) != 32'd0);
  assign post = (due && ac) ? NeverTime : entry.trig;

  ess_ram #(
    .WIDTH($bits(slot_entry_t)),
    .DEPTH(SLOT_TOTAL)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(rd_addr),
    .rdata_o(rdata)
  );

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    min_d      = min_q;
    earliest_d = earliest_q;
    rd_addr    = idx_q;
    we         = 1'b0;
    waddr      = idx_q;
    wdata      = entry;
    load       = 1'b0;
    okind_d    = KindAck;
    oslot_d    = '0;
    ocode_d    = '0;
    opay_d     = '0;
    oearl_d    = '0;
    olast_d    = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (in_accept) begin
          if (s_axis_tdata[2:0] == CmdRunUntil) begin
            rd_addr = '0;
            idx_d   = '0;
            min_d   = NeverTime;
            state_d = StRun;
          end else begin
            rd_addr = IdxW'(s_axis_tdata[7:3]);
            state_d = StCmd;
          end
        end
      end
      StCmd: begin
        rd_addr = IdxW'(slot_q);
        if (out_free) begin
          waddr = IdxW'(slot_q);
          if (ok) begin
            case (cmd_q) inside
              CmdSchedAbs, CmdSchedRel: begin
                we    = 1'b1;
                wdata = '{trig: nt, code: code_q, payload: pay_q};
                if (nt < earliest_q) earliest_d = nt;
              end
              CmdReschedAbs, CmdReschedRel: begin
                we         = 1'b1;
                wdata.trig = nt;
                if (nt < earliest_q) earliest_d = nt;
              end
              CmdDisable: begin
                we         = 1'b1;
                wdata.trig = NeverTime;
              end
              CmdCancel: begin
                we         = 1'b1;
                wdata.trig = NeverTime;
                wdata.code = '0;
              end
              default: we = 1'b0;
            endcase
          end
          load    = 1'b1;
          okind_d = KindAck;
          oslot_d = slot_q;
          oearl_d = earliest_d;
          olast_d = 1'b1;
          state_d = StIdle;
        end
      end
      StRun: begin
        if (!due || out_free) begin
          if (due) begin
            load    = 1'b1;
            okind_d = KindDue;
            oslot_d = SlotW'(idx_q);
            ocode_d = entry.code;
            opay_d  = entry.payload;
            if (ac) begin
              we         = 1'b1;
              wdata.trig = NeverTime;
              wdata.code = '0;
            end
          end
          if (post < min_q) min_d = post;
          rd_addr = idx_q + 1'b1;
          idx_d   = idx_q + 1'b1;
          if (idx_q == LastIdx) state_d = StFin;
        end
      end
      StFin: begin
        if (out_free) begin
          load       = 1'b1;
          okind_d    = KindDone;
          oearl_d    = min_q;
          olast_d    = 1'b1;
          earliest_d = min_q;
          state_d    = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      mask_q     <= '0;
      earliest_q <= NeverTime;
      vld_q      <= '0;
      rd_vld_q   <= 1'b0;
      ov_q       <= 1'b0;
      idx_q      <= '0;
      min_q      <= NeverTime;
    end else begin
      state_q    <= state_d;
      earliest_q <= earliest_d;
      idx_q      <= idx_d;
      min_q      <= min_d;
      rd_vld_q   <= vld_q[rd_addr];
      if (we) vld_q[waddr] <= 1'b1;
      if (cfg_valid_i) mask_q <= cfg_data_i;
      if (load) begin
        ov_q <= 1'b1;
      end else if (m_axis_tready) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_q  <= s_axis_tdata[2:0];
      slot_q <= s_axis_tdata[7:3];
      time_q <= s_axis_tdata[70:8];
      now_q  <= s_axis_tdata[133:71];
      code_q <= s_axis_tdata[141:134];
      pay_q  <= s_axis_tdata[157:142];
    end
    if (load) begin
      okind_q <= okind_d;
      oslot_q <= oslot_d;
      ocode_q <= ocode_d;
      opay_q  <= opay_d;
      oearl_q <= oearl_d;
      olast_q <= olast_d;
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tuser  = okind_q;
  assign m_axis_tlast  = olast_q;
  assign m_axis_tdata  = {4'b0000, oearl_q, opay_q, ocode_q, oslot_q};

  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRun && we) |-> (waddr != rd_addr))
    else $error("slot write collides with scan read");

  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && okind_d == KindDone) |-> olast_d)
    else $error("run finish item not marked last");

  a_due_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && okind_d == KindDue) |-> !olast_d)
    else $error("due item marked last");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !m_axis_tready) |-> !load)
    else $error("output register overwritten while held");

  a_run_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRun) |=> (state_q == StRun || state_q == StFin))
    else $error("scan left without finish item");

endmodule

@@ verif/tb_event_slot_scheduler_top.sv @@
// Testbench for event_slot_scheduler_top: directed table, random command mix, scoreboard.
`timescale 1ns / 100ps

module tb_event_slot_scheduler_top;
  import ess_pkg::*;

  localparam int SlotTotal = 32;
  localparam logic [CmdW-1:0] CmdUnused = 3'd7;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [SlotW-1:0] slot;
    logic [CodeW-1:0] code;
    logic [PayW-1:0]  pay;
    logic [TimeW-1:0] earliest;
    logic             is_last;
  } sched_result_t;

  // to_cfg rows write the mask held in tv[31:0]; typed rows fix the ack/done time
  typedef struct packed {
    logic             to_cfg;
    logic [CmdW-1:0]  cmd;
    logic [SlotW-1:0] slot;
    logic [TimeW-1:0] tv;
    logic [TimeW-1:0] now;
    logic [CodeW-1:0] code;
    logic [PayW-1:0]  pay;
    logic             typed;
    logic [TimeW-1:0] want;
  } dir_row_t;

  localparam int DirRows = 22;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [159:0]        s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [95:0]         m_axis_tdata;
  logic [1:0]          m_axis_tuser;
  logic                m_axis_tlast;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [MaskW-1:0]    cfg_data_i;

  logic [TimeW-1:0] shadow_trig [SlotTotal];
  logic [CodeW-1:0] shadow_code [SlotTotal];
  logic [PayW-1:0]  shadow_pay  [SlotTotal];
  logic [TimeW-1:0] shadow_earliest;
  logic [MaskW-1:0] shadow_mask;

  sched_result_t pending_results [$];
  int            fail_count = 0;
  bit            no_idle = 1'b0;

  dir_row_t dir_tab [DirRows] = '{
    '{1'b0, CmdRunUntil,   5'd0,  63'd0,          63'd0,          8'h00, 16'h0000, 1'b1,
      NeverTime},
    '{1'b1, CmdSchedAbs,   5'd0,  63'h0,          63'd0,          8'h00, 16'h0000, 1'b0, 63'd0},
    '{1'b0, CmdSchedAbs,   5'd0,  63'd0,          63'd0,          8'hff, 16'hffff, 1'b1, 63'd0},
    '{1'b0, CmdSchedRel,   5'd31, 63'd10,         NeverTime - 5,  8'h80, 16'h8000, 1'b1, 63'd0},
    '{1'b0, CmdSchedRel,   5'd1,  63'd50,         63'd100,        8'h01, 16'h0001, 1'b1, 63'd0},
    '{1'b0, CmdReschedAbs, 5'd2,  NeverTime - 1,  63'd0,          8'h00, 16'h0000, 1'b1, 63'd0},
    '{1'b0, CmdReschedRel, 5'd3,  NeverTime,      NeverTime,      8'h00, 16'h0000, 1'b1, 63'd0},
    '{1'b0, CmdSchedAbs,   5'd5,  63'd200,        63'd0,          8'h55, 16'haaaa, 1'b1, 63'd0},
    '{1'b0, CmdSchedAbs,   5'd7,  63'd300,        63'd0,          8'h00, 16'h1234, 1'b1, 63'd0},
    '{1'b0, CmdDisable,    5'd0,  63'd0,          63'd0,          8'h00, 16'h0000, 1'b1, 63'd0},
    '{1'b0, CmdCancel,     5'd1,  63'd0,          63'd0,          8'h00, 16'h0000, 1'b1, 63'd0},
    '{1'b0, CmdUnused,     5'd4,  63'd5,          63'd0,          8'h11, 16'h2222, 1'b1, 63'd0},
    '{1'b0, CmdRunUntil,   5'd0,  63'd250,        63'd0,          8'h00, 16'h0000, 1'b0, 63'd0},
    '{1'b0, CmdRunUntil,   5'd0,  NeverTime,      63'd0,          8'h00, 16'h0000, 1'b0, 63'd0},
    '{1'b1, CmdSchedAbs,   5'd0,  63'hffff_ffff,  63'd0,          8'h00, 16'h0000, 1'b0, 63'd0},
    '{1'b0, CmdSchedAbs,   5'd16, 63'd7,          63'd0,          8'h3c, 16'hc3c3, 1'b1, 63'd7},
    '{1'b0, CmdReschedRel, 5'd9,  63'd1,          NeverTime - 1,  8'h00, 16'h0000, 1'b1, 63'd7},
    '{1'b0, CmdRunUntil,   5'd0,  63'd7,          63'd0,          8'h00, 16'h0000, 1'b0, 63'd0},
    '{1'b0, CmdRunUntil,   5'd0,  NeverTime,      63'd0,          8'h00, 16'h0000, 1'b1,
      NeverTime},
    '{1'b1, CmdSchedAbs,   5'd0,  63'h8000_0001,  63'd0,          8'h00, 16'h0000, 1'b0, 63'd0},
    '{1'b0, CmdSchedRel,   5'd31, 63'd0,          63'd0,          8'hff, 16'h0000, 1'b1, 63'd0},
    '{1'b0, CmdRunUntil,   5'd0,  63'd0,          63'd0,          8'h00, 16'h0000, 1'b1,
      NeverTime}
  };

  event_slot_scheduler_top #(.SLOT_TOTAL(SlotTotal)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    for (int i = 0; i < SlotTotal; i++) begin
      shadow_trig[i] = NeverTime;
      shadow_code[i] = '0;
      shadow_pay[i]  = '0;
    end
    shadow_earliest = NeverTime;
    shadow_mask     = '0;
  end

  task automatic predict_scheduler(input logic [CmdW-1:0] cmd, input logic [SlotW-1:0] slot,
                                   input logic [TimeW-1:0] tv, input logic [TimeW-1:0] now,
                                   input logic [CodeW-1:0] code, input logic [PayW-1:0] pay);
    logic [TimeW:0]   sum;
    logic [TimeW-1:0] nt;
    if (cmd == CmdRunUntil) begin
      for (int i = 0; i < SlotTotal; i++) begin
        if (shadow_trig[i] <= tv) begin
          pending_results.push_back('{kind: KindDue, slot: i[SlotW-1:0], code: shadow_code[i],
                                      pay: shadow_pay[i], earliest: '0, is_last: 1'b0});
          if (shadow_mask[i]) begin
            shadow_code[i] = '0;
            shadow_trig[i] = NeverTime;
          end
        end
      end
      shadow_earliest = NeverTime;
      for (int i = 0; i < SlotTotal; i++)
        if (shadow_trig[i] < shadow_earliest) shadow_earliest = shadow_trig[i];
      pending_results.push_back('{kind: KindDone, slot: '0, code: '0, pay: '0,
                                  earliest: shadow_earliest, is_last: 1'b1});
    end else begin
      sum = {1'b0, now} + {1'b0, tv};
      if (cmd == CmdSchedRel || cmd == CmdReschedRel)
        nt = (sum > {1'b0, NeverTime}) ? NeverTime : sum[TimeW-1:0];
      else
        nt = tv;
      case (cmd)
        CmdSchedAbs, CmdSchedRel: begin
          shadow_trig[slot] = nt;
          shadow_code[slot] = code;
          shadow_pay[slot]  = pay;
          if (nt < shadow_earliest) shadow_earliest = nt;
        end
        CmdReschedAbs, CmdReschedRel: begin
          shadow_trig[slot] = nt;
          if (nt < shadow_earliest) shadow_earliest = nt;
        end
        CmdDisable: shadow_trig[slot] = NeverTime;
        CmdCancel: begin
          shadow_code[slot] = '0;
          shadow_trig[slot] = NeverTime;
        end
        default: ;
      endcase
      pending_results.push_back('{kind: KindAck, slot: slot, code: '0, pay: '0,
                                  earliest: shadow_earliest, is_last: 1'b1});
    end
  endtask

  task automatic drive_command(input logic [CmdW-1:0] cmd, input logic [SlotW-1:0] slot,
                               input logic [TimeW-1:0] tv, input logic [TimeW-1:0] now,
                               input logic [CodeW-1:0] code, input logic [PayW-1:0] pay);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
    end
    @(negedge clk_i);
    s_axis_tdata  = {2'b00, pay, code, now, tv, slot, cmd};
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_scheduler(cmd, slot, tv, now, code, pay);
  endtask

  // drains all results before touching the mask
  task automatic load_autocancel(input logic [MaskW-1:0] mask);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    cfg_data_i  = mask;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    shadow_mask = mask;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic void check_field(input string what, input logic [TimeW-1:0] want,
                                      input logic [TimeW-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      fail_count++;
    end
  endfunction

  initial begin : result_monitor
    sched_result_t want;
    sched_result_t got;
    int stall;
    m_axis_tready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 3);
      repeat (stall) begin
        @(negedge clk_i);
        m_axis_tready = 1'b0;
      end
      @(negedge clk_i);
      m_axis_tready = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      got = '{kind: m_axis_tuser, slot: m_axis_tdata[4:0], code: m_axis_tdata[12:5],
              pay: m_axis_tdata[28:13], earliest: m_axis_tdata[91:29], is_last: m_axis_tlast};
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected item, expected none, actual kind %0h slot %0d earliest %0h",
                 $time, got.kind, got.slot, got.earliest);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("item_kind", want.kind, got.kind);
        check_field("due_slot", want.slot, got.slot);
        check_field("due_code", want.code, got.code);
        check_field("due_payload", want.pay, got.pay);
        check_field("earliest_trigger", want.earliest, got.earliest);
        check_field("tlast", want.is_last, got.is_last);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    dir_row_t         row;
    logic [CmdW-1:0]  cmd;
    logic [TimeW-1:0] tv;
    logic [TimeW-1:0] now;
    logic [TimeW-1:0] base_time;
    logic [MaskW-1:0] mask;
    int               sel;
    int               tsel;
    bit               relative;

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    base_time     = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_tab[k]) begin
      row = dir_tab[k];
      if (row.to_cfg) begin
        load_autocancel(row.tv[MaskW-1:0]);
      end else begin
        drive_command(row.cmd, row.slot, row.tv, row.now, row.code, row.pay);
        if (row.typed) pending_results[pending_results.size()-1].earliest = row.want;
      end
    end

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: mask = $urandom;
        1: mask = 32'h0000_0000;
        2: mask = 32'hffff_ffff;
        default: mask = 32'h5a5a_a5a5;
      endcase
      load_autocancel(mask);
      no_idle = (ph == 2);
      for (int n = 0; n < 80; n++) begin
        sel = $urandom_range(0, 99);
        cmd = sel < 22 ? CmdSchedAbs : sel < 42 ? CmdSchedRel : sel < 52 ? CmdReschedAbs :
              sel < 62 ? CmdReschedRel : sel < 70 ? CmdDisable : sel < 78 ? CmdCancel :
              sel < 97 ? CmdRunUntil : CmdUnused;
        relative = (cmd == CmdSchedRel || cmd == CmdReschedRel);
        now = ($urandom_range(0, 9) == 0) ? TimeW'({$urandom, $urandom}) : base_time;
        tsel = $urandom_range(0, 19);
        if (tsel == 0)
          tv = TimeW'({$urandom, $urandom});
        else if (tsel == 1)
          tv = NeverTime - TimeW'($urandom_range(0, 3));
        else if (relative)
          tv = TimeW'($urandom_range(0, 2000));
        else
          tv = base_time + TimeW'($urandom_range(0, 2000));
        // keep the working clock moving forward and far from never
        if (cmd == CmdRunUntil && tv > base_time && tv < (TimeW'(1) << 48)) base_time = tv;
        drive_command(cmd, SlotW'($urandom_range(0, SlotTotal - 1)), tv, now,
                      CodeW'($urandom), PayW'($urandom));
      end
    end
    no_idle = 1'b0;

    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SlotTotal + 8) @(posedge clk_i);
    if (fail_count == 0 && pending_results.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
